[rtl/core/ism3d_pkg.sv]
`default_nettype none

package ism3d_pkg;

  localparam int COORD_W      = 4;
  localparam int THR_W        = 11;
  localparam int FIELD_W      = 5;
  localparam int MAG_OUT_W    = 14;
  localparam int ENERGY_OUT_W = 18;
  localparam int CNT_OUT_W    = 25;
  localparam int SUM_M_W      = 38;
  localparam int SUM_E_W      = 42;
  localparam int SUM_M2_W     = 49;
  localparam int SUM_E2_W     = 58;
  localparam int SUM_AM_W     = 37;

  localparam logic CMD_MOVE    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  localparam logic signed [FIELD_W-1:0] FIELD_RESET = 5'sd1;

  typedef struct packed {
    logic capture;
    logic rd_b;
    logic rd_c;
    logic eval;
    logic sqr;
    logic acc;
    logic clr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/core/ism3d_move_if.sv]
`default_nettype none

interface ism3d_move_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     command;
  logic        [ism3d_pkg::COORD_W-1:0]     site_x;
  logic        [ism3d_pkg::COORD_W-1:0]     site_y;
  logic        [ism3d_pkg::COORD_W-1:0]     site_z;
  logic signed [ism3d_pkg::THR_W-1:0]       accept_threshold;

  modport source(output valid, command, site_x, site_y, site_z, accept_threshold,
                 input ready);
  modport sink(input valid, command, site_x, site_y, site_z, accept_threshold,
               output ready);
endinterface

`default_nettype wire

[rtl/core/ism3d_result_if.sv]
`default_nettype none

interface ism3d_result_if;
  logic                                      valid;
  logic                                      ready;
  logic                                      accepted;
  logic signed [ism3d_pkg::MAG_OUT_W-1:0]    magnetization;
  logic signed [ism3d_pkg::ENERGY_OUT_W-1:0] energy_x2;
  logic        [ism3d_pkg::CNT_OUT_W-1:0]    moves_counted;
  logic signed [ism3d_pkg::SUM_M_W-1:0]      sum_magnetization;
  logic signed [ism3d_pkg::SUM_E_W-1:0]      sum_energy;
  logic        [ism3d_pkg::SUM_M2_W-1:0]     sum_magnetization_sq;
  logic        [ism3d_pkg::SUM_E2_W-1:0]     sum_energy_sq;
  logic        [ism3d_pkg::SUM_AM_W-1:0]     sum_abs_magnetization;

  modport source(output valid, accepted, magnetization, energy_x2, moves_counted,
                 sum_magnetization, sum_energy, sum_magnetization_sq, sum_energy_sq,
                 sum_abs_magnetization, input ready);
  modport sink(input valid, accepted, magnetization, energy_x2, moves_counted,
               sum_magnetization, sum_energy, sum_magnetization_sq, sum_energy_sq,
               sum_abs_magnetization, output ready);
endinterface

`default_nettype wire

[rtl/core/ism3d_ctrl.sv]
`default_nettype none

module ism3d_ctrl (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  input  wire                     in_command,
  output logic                    in_ready,
  input  wire                     out_ready,
  output logic                    out_valid,
  output ism3d_pkg::ctrl_cmd_t    cmd,
  input  ism3d_pkg::dp_status_t   sts
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RD_B  = 3'd2;
  localparam logic [2:0] ST_RD_C  = 3'd3;
  localparam logic [2:0] ST_EVAL  = 3'd4;
  localparam logic [2:0] ST_SQR   = 3'd5;
  localparam logic [2:0] ST_ACC   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       report_r, report_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_fire;
  logic       out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    report_nxt    = report_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.capture   = in_fire;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = report_r ? ST_ACC : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (in_command == ism3d_pkg::CMD_RESTART) begin
            state_nxt  = ST_CLEAR;
            report_nxt = 1'b1;
          end else begin
            state_nxt = ST_RD_B;
          end
        end
      end
      ST_RD_B: begin
        cmd.rd_b  = 1'b1;
        state_nxt = ST_RD_C;
      end
      ST_RD_C: begin
        cmd.rd_c  = 1'b1;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = ST_SQR;
      end
      ST_SQR: begin
        cmd.sqr   = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (out_free) begin
          cmd.acc       = 1'b1;
          out_valid_nxt = 1'b1;
          report_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      report_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      report_r    <= report_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/ism3d_datapath.sv]
`default_nettype none

module ism3d_datapath #(
  parameter int LATTICE_SIDE   = 16,
  parameter int MAX_MOVES_LOG2 = 24
) (
  input  wire                                        clk,
  input  wire                                        rst_n,
  input  wire                                        cfg_wr_en,
  input  wire  [ism3d_pkg::FIELD_W-1:0]              cfg_wr_data,
  input  wire                                        in_command,
  input  wire  [ism3d_pkg::COORD_W-1:0]              in_site_x,
  input  wire  [ism3d_pkg::COORD_W-1:0]              in_site_y,
  input  wire  [ism3d_pkg::COORD_W-1:0]              in_site_z,
  input  wire  signed [ism3d_pkg::THR_W-1:0]         in_accept_threshold,
  input  ism3d_pkg::ctrl_cmd_t                       cmd,
  output ism3d_pkg::dp_status_t                      sts,
  output logic                                       out_accepted,
  output logic signed [ism3d_pkg::MAG_OUT_W-1:0]     out_magnetization,
  output logic signed [ism3d_pkg::ENERGY_OUT_W-1:0]  out_energy_x2,
  output logic        [ism3d_pkg::CNT_OUT_W-1:0]     out_moves_counted,
  output logic signed [ism3d_pkg::SUM_M_W-1:0]       out_sum_magnetization,
  output logic signed [ism3d_pkg::SUM_E_W-1:0]       out_sum_energy,
  output logic        [ism3d_pkg::SUM_M2_W-1:0]      out_sum_magnetization_sq,
  output logic        [ism3d_pkg::SUM_E2_W-1:0]      out_sum_energy_sq,
  output logic        [ism3d_pkg::SUM_AM_W-1:0]      out_sum_abs_magnetization
);

  localparam int CW      = $clog2(LATTICE_SIDE);
  localparam int RAW     = 2 * CW;
  localparam int DEPTH   = 1 << RAW;
  localparam int SITES   = LATTICE_SIDE * LATTICE_SIDE * LATTICE_SIDE;
  localparam int MAW     = $clog2(SITES + 1);
  localparam int MW      = MAW + 1;
  localparam int H_MAX   = 1 << (ism3d_pkg::FIELD_W - 1);
  localparam int E_BOUND = 2 * SITES * (3 + H_MAX);
  localparam int EAW     = $clog2(E_BOUND + 1);
  localparam int EW      = EAW + 1;
  localparam int CNTW    = MAX_MOVES_LOG2 + 1;
  localparam int FW      = ism3d_pkg::FIELD_W;

  localparam logic signed [MW-1:0] M_RESET = MW'(SITES);
  localparam logic signed [MW-1:0] M_STEP  = MW'(2);
  localparam logic signed [EW-1:0] E_RESET = EW'(-8 * SITES);
  localparam logic signed [EW-1:0] E_SCALE = EW'(-2 * SITES);

  function automatic logic [CW-1:0] coord_reduce(input logic [ism3d_pkg::COORD_W-1:0] c);
    logic [CW-1:0] r;
    r = '0;
    for (int v = 0; v < (1 << ism3d_pkg::COORD_W); v++) begin
      if (c == ism3d_pkg::COORD_W'(v)) begin
        r = CW'(v % LATTICE_SIDE);
      end
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] wrap_dec(input logic [CW-1:0] c);
    return (c == '0) ? CW'(LATTICE_SIDE - 1) : c - 1'b1;
  endfunction

  function automatic logic [CW-1:0] wrap_inc(input logic [CW-1:0] c);
    return (c == CW'(LATTICE_SIDE - 1)) ? '0 : c + 1'b1;
  endfunction

  logic [LATTICE_SIDE-1:0] mem [0:DEPTH-1];
  logic [LATTICE_SIDE-1:0] rdata0_r, rdata1_r;
  logic [RAW-1:0]          raddr0, raddr1, waddr;
  logic [LATTICE_SIDE-1:0] wdata;
  logic                    we;

  logic signed [FW-1:0]    field_r;
  logic [RAW-1:0]          clr_cnt_r;

  logic [CW-1:0]           xin, yin, zin;
  logic [CW-1:0]           x_r, y_r, z_r;
  logic                    cmd_r;
  logic signed [ism3d_pkg::THR_W-1:0] thr_r;

  logic [LATTICE_SIDE-1:0] center_row_r;
  logic                    nb_xa_r, nb_xb_r, nb_ya_r;
  logic                    flip_r;

  logic                    s_down;
  logic [2:0]              downs;
  logic signed [3:0]       sj;
  logic signed [5:0]       hs;
  logic signed [5:0]       loc;
  logic signed [6:0]       loc7;
  logic signed [6:0]       dval;
  logic signed [7:0]       de;
  logic                    flip;
  logic signed [FW:0]      h_plus3;
  logic signed [EW-1:0]    e_restart;

  logic signed [MW-1:0]    m_r, m_nxt;
  logic signed [EW-1:0]    e_r, e_nxt;
  logic [CNTW-1:0]         cnt_r, cnt_nxt;
  logic signed [ism3d_pkg::SUM_M_W-1:0]  acc_m_r, acc_m_nxt;
  logic signed [ism3d_pkg::SUM_E_W-1:0]  acc_e_r, acc_e_nxt;
  logic [ism3d_pkg::SUM_M2_W-1:0]        acc_m2_r, acc_m2_nxt;
  logic [ism3d_pkg::SUM_E2_W-1:0]        acc_e2_r, acc_e2_nxt;
  logic [ism3d_pkg::SUM_AM_W-1:0]        acc_am_r, acc_am_nxt;

  logic [MAW-1:0]          am, am_r;
  logic [EAW-1:0]          ae;
  logic [2*MAW-1:0]        m_sq_r;
  logic [2*EAW-1:0]        e_sq_r;

  assign xin = coord_reduce(in_site_x);
  assign yin = coord_reduce(in_site_y);
  assign zin = coord_reduce(in_site_z);

  always_comb begin
    if (cmd.rd_b) begin
      raddr0 = {wrap_inc(x_r), y_r};
      raddr1 = {x_r, wrap_dec(y_r)};
    end else if (cmd.rd_c) begin
      raddr0 = {x_r, wrap_inc(y_r)};
      raddr1 = {x_r, y_r};
    end else begin
      raddr0 = {xin, yin};
      raddr1 = {wrap_dec(xin), yin};
    end
  end

  assign we    = cmd.clr || (cmd.eval && flip);
  assign waddr = cmd.clr ? clr_cnt_r : {x_r, y_r};
  assign wdata = cmd.clr ? '0 : (center_row_r ^ (LATTICE_SIDE'(1) << z_r));

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0_r <= mem[raddr0];
    rdata1_r <= mem[raddr1];
  end

  assign sts.clr_last = &clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_r   <= ism3d_pkg::FIELD_RESET;
      clr_cnt_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        field_r <= cfg_wr_data;
      end
      if (cmd.clr) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r   <= xin;
      y_r   <= yin;
      z_r   <= zin;
      cmd_r <= in_command;
      thr_r <= in_accept_threshold;
    end
    if (cmd.rd_b) begin
      center_row_r <= rdata0_r;
      nb_xa_r      <= rdata1_r[z_r];
    end
    if (cmd.rd_c) begin
      nb_xb_r <= rdata0_r[z_r];
      nb_ya_r <= rdata1_r[z_r];
    end
    if (cmd.eval) begin
      flip_r <= flip;
    end
  end

  always_comb begin
    s_down = center_row_r[z_r];
    downs  = 3'(nb_xa_r) + 3'(nb_xb_r) + 3'(nb_ya_r) + 3'(rdata0_r[z_r])
           + 3'(center_row_r[wrap_dec(z_r)]) + 3'(center_row_r[wrap_inc(z_r)]);
    sj     = 4'(4'd6 - {downs, 1'b0});
    hs     = 6'(field_r) + 6'(sj);
    loc    = s_down ? -hs : hs;
    loc7   = 7'(loc);
    dval   = -(loc7 + loc7);
    de     = 8'(loc) <<< 2;
    flip   = 11'(dval) > thr_r;
  end

  assign h_plus3   = (FW + 1)'(field_r) + (FW + 1)'(3);
  assign e_restart = EW'(h_plus3) * E_SCALE;

  assign am = m_r[MW-1] ? MAW'(-m_r) : MAW'(m_r);
  assign ae = e_r[EW-1] ? EAW'(-e_r) : EAW'(e_r);

  always_ff @(posedge clk) begin
    if (cmd.sqr) begin
      am_r   <= am;
      m_sq_r <= am * am;
      e_sq_r <= ae * ae;
    end
  end

  always_comb begin
    m_nxt      = m_r;
    e_nxt      = e_r;
    cnt_nxt    = cnt_r;
    acc_m_nxt  = acc_m_r;
    acc_e_nxt  = acc_e_r;
    acc_m2_nxt = acc_m2_r;
    acc_e2_nxt = acc_e2_r;
    acc_am_nxt = acc_am_r;
    if (cmd.eval && flip) begin
      m_nxt = m_r + (s_down ? M_STEP : -M_STEP);
      e_nxt = e_r + EW'(de);
    end
    if (cmd.acc) begin
      if (cmd_r == ism3d_pkg::CMD_RESTART) begin
        m_nxt      = M_RESET;
        e_nxt      = e_restart;
        cnt_nxt    = '0;
        acc_m_nxt  = '0;
        acc_e_nxt  = '0;
        acc_m2_nxt = '0;
        acc_e2_nxt = '0;
        acc_am_nxt = '0;
      end else if (!cnt_r[CNTW-1]) begin
        cnt_nxt    = cnt_r + 1'b1;
        acc_m_nxt  = acc_m_r + ism3d_pkg::SUM_M_W'(m_r);
        acc_e_nxt  = acc_e_r + ism3d_pkg::SUM_E_W'(e_r);
        acc_m2_nxt = acc_m2_r + ism3d_pkg::SUM_M2_W'(m_sq_r);
        acc_e2_nxt = acc_e2_r + ism3d_pkg::SUM_E2_W'(e_sq_r);
        acc_am_nxt = acc_am_r + ism3d_pkg::SUM_AM_W'(am_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r      <= M_RESET;
      e_r      <= E_RESET;
      cnt_r    <= '0;
      acc_m_r  <= '0;
      acc_e_r  <= '0;
      acc_m2_r <= '0;
      acc_e2_r <= '0;
      acc_am_r <= '0;
    end else begin
      m_r      <= m_nxt;
      e_r      <= e_nxt;
      cnt_r    <= cnt_nxt;
      acc_m_r  <= acc_m_nxt;
      acc_e_r  <= acc_e_nxt;
      acc_m2_r <= acc_m2_nxt;
      acc_e2_r <= acc_e2_nxt;
      acc_am_r <= acc_am_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      out_accepted              <= (cmd_r == ism3d_pkg::CMD_MOVE) && flip_r;
      out_magnetization         <= ism3d_pkg::MAG_OUT_W'(m_nxt);
      out_energy_x2             <= ism3d_pkg::ENERGY_OUT_W'(e_nxt);
      out_moves_counted         <= ism3d_pkg::CNT_OUT_W'(cnt_nxt);
      out_sum_magnetization     <= acc_m_nxt;
      out_sum_energy            <= acc_e_nxt;
      out_sum_magnetization_sq  <= acc_m2_nxt;
      out_sum_energy_sq         <= acc_e2_nxt;
      out_sum_abs_magnetization <= acc_am_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/ising_metropolis_3d_step.sv]
// Metropolis spin-flip engine for a periodic 3D Ising lattice, one bit per site, held as
// rows along z in a dual-read-port memory. A move beat has its result registered after
// the accepting edge: the neighbor rows come in over three reads (two rows per read, the
// first at the accepting edge), then one step evaluates and writes the flipped row back,
// one squares M and E, and one accumulates; in_move.ready returns together with
// out_result.valid, so moves are taken one at a time, a new one only once the last one's
// result is registered, while the result beat waits in its own register. A result still
// unaccepted when the next one is due holds that move in its accumulate step.
// A restart beat, and likewise reset, runs a clearing pass over 2^(2*ceil(log2(LATTICE_SIDE)))
// rows (256 rows at LATTICE_SIDE = 16) during which no beat is taken; a restart then
// returns its result from its accumulate step. cfg_wr_en loads the field strength at any time.
`default_nettype none

module ising_metropolis_3d_step #(
  parameter int LATTICE_SIDE   = 16,
  parameter int MAX_MOVES_LOG2 = 24
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            cfg_wr_en,
  input  wire [ism3d_pkg::FIELD_W-1:0]   cfg_wr_data,
  ism3d_move_if.sink                     in_move,
  ism3d_result_if.source                 out_result
);

  ism3d_pkg::ctrl_cmd_t  cmd;
  ism3d_pkg::dp_status_t sts;

  ism3d_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_move.valid),
    .in_command (in_move.command),
    .in_ready   (in_move.ready),
    .out_ready  (out_result.ready),
    .out_valid  (out_result.valid),
    .cmd        (cmd),
    .sts        (sts)
  );

  ism3d_datapath #(
    .LATTICE_SIDE   (LATTICE_SIDE),
    .MAX_MOVES_LOG2 (MAX_MOVES_LOG2)
  ) u_datapath (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .cfg_wr_en                 (cfg_wr_en),
    .cfg_wr_data               (cfg_wr_data),
    .in_command                (in_move.command),
    .in_site_x                 (in_move.site_x),
    .in_site_y                 (in_move.site_y),
    .in_site_z                 (in_move.site_z),
    .in_accept_threshold       (in_move.accept_threshold),
    .cmd                       (cmd),
    .sts                       (sts),
    .out_accepted              (out_result.accepted),
    .out_magnetization         (out_result.magnetization),
    .out_energy_x2             (out_result.energy_x2),
    .out_moves_counted         (out_result.moves_counted),
    .out_sum_magnetization     (out_result.sum_magnetization),
    .out_sum_energy            (out_result.sum_energy),
    .out_sum_magnetization_sq  (out_result.sum_magnetization_sq),
    .out_sum_energy_sq         (out_result.sum_energy_sq),
    .out_sum_abs_magnetization (out_result.sum_abs_magnetization)
  );

endmodule

`default_nettype wire

[rtl/core/ism3d_checker.sv]
`default_nettype none

module ism3d_checker (
  input wire                                        clk,
  input wire                                        rst_n,
  input wire                                        in_valid,
  input wire                                        in_ready,
  input wire                                        out_valid,
  input wire                                        out_ready,
  input wire                                        out_accepted,
  input wire signed [ism3d_pkg::MAG_OUT_W-1:0]      out_magnetization,
  input wire signed [ism3d_pkg::ENERGY_OUT_W-1:0]   out_energy_x2,
  input wire        [ism3d_pkg::CNT_OUT_W-1:0]      out_moves_counted
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_accepted)
      && $stable(out_magnetization) && $stable(out_energy_x2)
      && $stable(out_moves_counted))
    else $error("result beat changed while stalled");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !in_ready)
    else $error("move beat taken during clearing pass");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while a move is in flight");

  a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("input not ready when result beat appears");

endmodule

bind ising_metropolis_3d_step ism3d_checker u_ism3d_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_move.valid),
  .in_ready          (in_move.ready),
  .out_valid         (out_result.valid),
  .out_ready         (out_result.ready),
  .out_accepted      (out_result.accepted),
  .out_magnetization (out_result.magnetization),
  .out_energy_x2     (out_result.energy_x2),
  .out_moves_counted (out_result.moves_counted)
);

`default_nettype wire

[tb/ising_metropolis_3d_step_check.sv]
`timescale 1ns / 100ps
`default_nettype none

module ising_metropolis_3d_step_check #(
  parameter int LATTICE_SIDE   = 16,
  parameter int MAX_MOVES_LOG2 = 24
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_wr_en,
  input  wire [ism3d_pkg::FIELD_W-1:0]      cfg_wr_data,
  ism3d_move_if                             move_mon,
  ism3d_result_if                           result_mon,
  output int                                fail_count,
  output int                                pending_count
);

  localparam int SITES = LATTICE_SIDE * LATTICE_SIDE * LATTICE_SIDE;

  typedef struct {
    logic                                      accepted;
    logic signed [ism3d_pkg::MAG_OUT_W-1:0]    magnetization;
    logic signed [ism3d_pkg::ENERGY_OUT_W-1:0] energy_x2;
    logic        [ism3d_pkg::CNT_OUT_W-1:0]    moves_counted;
    logic signed [ism3d_pkg::SUM_M_W-1:0]      sum_magnetization;
    logic signed [ism3d_pkg::SUM_E_W-1:0]      sum_energy;
    logic        [ism3d_pkg::SUM_M2_W-1:0]     sum_magnetization_sq;
    logic        [ism3d_pkg::SUM_E2_W-1:0]     sum_energy_sq;
    logic        [ism3d_pkg::SUM_AM_W-1:0]     sum_abs_magnetization;
  } lattice_report_t;

  lattice_report_t                      lattice_reports_q[$];
  lattice_report_t                      report_want;
  bit                                   spin_down [SITES];
  logic signed [ism3d_pkg::FIELD_W-1:0] field_h;
  longint                               mag_total;
  longint                               energy_x2_total;
  longint                               moves_total;
  longint                               sum_m;
  longint                               sum_e;
  longint                               sum_m2;
  longint                               sum_e2;
  longint                               sum_am;

  function automatic int site_of(int x, int y, int z);
    return (x * LATTICE_SIDE + y) * LATTICE_SIDE + z;
  endfunction

  function int spin_at(int x, int y, int z);
    return spin_down[site_of(x, y, z)] ? -1 : 1;
  endfunction

  function void restart_lattice();
    foreach (spin_down[i]) spin_down[i] = 1'b0;
    mag_total       = SITES;
    energy_x2_total = -2 * longint'(SITES) * (3 + longint'(field_h));
    moves_total     = 0;
    sum_m           = 0;
    sum_e           = 0;
    sum_m2          = 0;
    sum_e2          = 0;
    sum_am          = 0;
  endfunction

  function void apply_beat(logic cmd, logic [ism3d_pkg::COORD_W-1:0] sx,
                           logic [ism3d_pkg::COORD_W-1:0] sy,
                           logic [ism3d_pkg::COORD_W-1:0] sz,
                           logic signed [ism3d_pkg::THR_W-1:0] thr);
    int              x;
    int              y;
    int              z;
    int              nb_sum;
    int              s;
    longint          bond;
    longint          am;
    longint          ae;
    lattice_report_t r;
    r.accepted = 1'b0;
    if (cmd == ism3d_pkg::CMD_RESTART) begin
      restart_lattice();
    end else begin
      x = int'(sx) % LATTICE_SIDE;
      y = int'(sy) % LATTICE_SIDE;
      z = int'(sz) % LATTICE_SIDE;
      nb_sum = spin_at((x + LATTICE_SIDE - 1) % LATTICE_SIDE, y, z)
             + spin_at((x + 1) % LATTICE_SIDE, y, z)
             + spin_at(x, (y + LATTICE_SIDE - 1) % LATTICE_SIDE, z)
             + spin_at(x, (y + 1) % LATTICE_SIDE, z)
             + spin_at(x, y, (z + LATTICE_SIDE - 1) % LATTICE_SIDE)
             + spin_at(x, y, (z + 1) % LATTICE_SIDE);
      s    = spin_at(x, y, z);
      bond = s * (longint'(field_h) + nb_sum);
      if (-2 * bond > longint'(thr)) begin
        spin_down[site_of(x, y, z)] = ~spin_down[site_of(x, y, z)];
        mag_total       += -2 * s;
        energy_x2_total += 4 * bond;
        r.accepted = 1'b1;
      end
      if (moves_total < (longint'(1) << MAX_MOVES_LOG2)) begin
        am = (mag_total < 0) ? -mag_total : mag_total;
        ae = (energy_x2_total < 0) ? -energy_x2_total : energy_x2_total;
        moves_total++;
        sum_m  += mag_total;
        sum_e  += energy_x2_total;
        sum_m2 += am * am;
        sum_e2 += ae * ae;
        sum_am += am;
      end
    end
    r.magnetization         = mag_total[ism3d_pkg::MAG_OUT_W-1:0];
    r.energy_x2             = energy_x2_total[ism3d_pkg::ENERGY_OUT_W-1:0];
    r.moves_counted         = moves_total[ism3d_pkg::CNT_OUT_W-1:0];
    r.sum_magnetization     = sum_m[ism3d_pkg::SUM_M_W-1:0];
    r.sum_energy            = sum_e[ism3d_pkg::SUM_E_W-1:0];
    r.sum_magnetization_sq  = sum_m2[ism3d_pkg::SUM_M2_W-1:0];
    r.sum_energy_sq         = sum_e2[ism3d_pkg::SUM_E2_W-1:0];
    r.sum_abs_magnetization = sum_am[ism3d_pkg::SUM_AM_W-1:0];
    lattice_reports_q.push_back(r);
  endfunction

  function void check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      field_h = ism3d_pkg::FIELD_RESET;
      restart_lattice();
      lattice_reports_q.delete();
    end else begin
      if (result_mon.valid && result_mon.ready) begin
        if (lattice_reports_q.size() == 0) begin
          $error("result beat with no move outstanding");
          fail_count++;
        end else begin
          report_want = lattice_reports_q.pop_front();
          check_field("accepted", report_want.accepted, result_mon.accepted);
          check_field("magnetization", report_want.magnetization, result_mon.magnetization);
          check_field("energy_x2", report_want.energy_x2, result_mon.energy_x2);
          check_field("moves_counted", report_want.moves_counted, result_mon.moves_counted);
          check_field("sum_magnetization", report_want.sum_magnetization,
                      result_mon.sum_magnetization);
          check_field("sum_energy", report_want.sum_energy, result_mon.sum_energy);
          check_field("sum_magnetization_sq", report_want.sum_magnetization_sq,
                      result_mon.sum_magnetization_sq);
          check_field("sum_energy_sq", report_want.sum_energy_sq, result_mon.sum_energy_sq);
          check_field("sum_abs_magnetization", report_want.sum_abs_magnetization,
                      result_mon.sum_abs_magnetization);
        end
      end
      if (move_mon.valid && move_mon.ready) begin
        apply_beat(move_mon.command, move_mon.site_x, move_mon.site_y, move_mon.site_z,
                   move_mon.accept_threshold);
      end
      if (cfg_wr_en) begin
        field_h = cfg_wr_data;
      end
    end
    pending_count <= lattice_reports_q.size();
  end

endmodule

`default_nettype wire

[tb/ising_metropolis_3d_step_test.sv]
`timescale 1ns / 100ps
`default_nettype none

module ising_metropolis_3d_step_test;

  localparam int LATTICE_SIDE   = 16;
  localparam int MAX_MOVES_LOG2 = 24;
  localparam int LIMIT_CYCLES   = 500000;
  localparam int PHASE_ITEMS    = 250;
  localparam int DRAIN_CYCLES   = 300;
  localparam int FIELD_STEPS [8] = '{1, -10, 10, 0, 15, -16, -3, 6};

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_wr_en;
  logic [ism3d_pkg::FIELD_W-1:0] cfg_wr_data;
  int                            fail_count;
  int                            pending_count;
  int                            cycle_count;
  int                            snd_idle_pct;
  int                            rcv_stall_pct;

  ism3d_move_if   move_if ();
  ism3d_result_if res_if ();

  ising_metropolis_3d_step #(
    .LATTICE_SIDE   (LATTICE_SIDE),
    .MAX_MOVES_LOG2 (MAX_MOVES_LOG2)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_move     (move_if),
    .out_result  (res_if)
  );

  ising_metropolis_3d_step_check #(
    .LATTICE_SIDE   (LATTICE_SIDE),
    .MAX_MOVES_LOG2 (MAX_MOVES_LOG2)
  ) i_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .move_mon      (move_if),
    .result_mon    (res_if),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    res_if.ready <= rst_n && ($urandom_range(99) >= rcv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("ising_metropolis_3d_step_test: FAIL");
      $finish;
    end
  end

  task automatic send_beat(input logic cmd, input logic [ism3d_pkg::COORD_W-1:0] sx,
                           input logic [ism3d_pkg::COORD_W-1:0] sy,
                           input logic [ism3d_pkg::COORD_W-1:0] sz,
                           input logic signed [ism3d_pkg::THR_W-1:0] thr);
    while ($urandom_range(99) < snd_idle_pct) begin
      move_if.valid <= 1'b0;
      @(posedge clk);
    end
    move_if.valid            <= 1'b1;
    move_if.command          <= cmd;
    move_if.site_x           <= sx;
    move_if.site_y           <= sy;
    move_if.site_z           <= sz;
    move_if.accept_threshold <= thr;
    do @(posedge clk); while (!move_if.ready);
  endtask

  task automatic wait_drained(input int extra_cycles);
    move_if.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (extra_cycles) @(posedge clk);
  endtask

  task automatic write_field(input logic signed [ism3d_pkg::FIELD_W-1:0] h);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= h;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    logic                               cmd;
    logic signed [ism3d_pkg::THR_W-1:0] thr;
    int                                 pick;
    cycle_count              = 0;
    snd_idle_pct             = 0;
    rcv_stall_pct            = 0;
    rst_n                    = 1'b0;
    cfg_wr_en                = 1'b0;
    cfg_wr_data              = '0;
    move_if.valid            = 1'b0;
    move_if.command          = ism3d_pkg::CMD_MOVE;
    move_if.site_x           = '0;
    move_if.site_y           = '0;
    move_if.site_z           = '0;
    move_if.accept_threshold = '0;
    res_if.ready             = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: wrap at the lattice edges, threshold extremes, field extremes
    send_beat(ism3d_pkg::CMD_RESTART, 15, 15, 15, 1023);
    send_beat(ism3d_pkg::CMD_MOVE, 0, 0, 0, -1024);
    send_beat(ism3d_pkg::CMD_MOVE, 0, 0, 0, -1024);
    send_beat(ism3d_pkg::CMD_MOVE, 15, 15, 15, 0);
    send_beat(ism3d_pkg::CMD_MOVE, 15, 0, 15, -15);
    send_beat(ism3d_pkg::CMD_MOVE, 15, 0, 15, 13);
    send_beat(ism3d_pkg::CMD_MOVE, 0, 15, 0, 1023);
    send_beat(ism3d_pkg::CMD_MOVE, 1, 0, 0, -1024);
    send_beat(ism3d_pkg::CMD_MOVE, 0, 0, 0, -1);
    wait_drained(8);
    write_field(15);
    send_beat(ism3d_pkg::CMD_RESTART, 0, 0, 0, -1024);
    send_beat(ism3d_pkg::CMD_MOVE, 0, 0, 0, 0);
    send_beat(ism3d_pkg::CMD_MOVE, 0, 0, 0, -43);
    send_beat(ism3d_pkg::CMD_MOVE, 0, 0, 0, -1);
    wait_drained(8);
    // hold the energy register across a field change
    write_field(-16);
    send_beat(ism3d_pkg::CMD_MOVE, 7, 8, 9, 0);
    send_beat(ism3d_pkg::CMD_MOVE, 7, 8, 9, 1023);
    send_beat(ism3d_pkg::CMD_RESTART, 8, 8, 8, 0);
    send_beat(ism3d_pkg::CMD_MOVE, 8, 8, 8, 19);
    send_beat(ism3d_pkg::CMD_MOVE, 15, 15, 0, -1024);

    for (int phase = 0; phase < 8; phase++) begin
      wait_drained(8);
      write_field(ism3d_pkg::FIELD_W'(FIELD_STEPS[phase]));
      case (phase % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 48; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 48; end
        default: begin snd_idle_pct = 26; rcv_stall_pct = 26; end
      endcase
      if ($urandom_range(1) == 1) begin
        send_beat(ism3d_pkg::CMD_RESTART, ism3d_pkg::COORD_W'($urandom),
                  ism3d_pkg::COORD_W'($urandom), ism3d_pkg::COORD_W'($urandom),
                  ism3d_pkg::THR_W'($urandom));
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        cmd  = ($urandom_range(99) < 2) ? ism3d_pkg::CMD_RESTART : ism3d_pkg::CMD_MOVE;
        pick = $urandom_range(9);
        if (pick < 5) begin
          thr = ism3d_pkg::THR_W'(-int'($urandom_range(50)));
        end else if (pick < 8) begin
          thr = ism3d_pkg::THR_W'(-int'($urandom_range(1024)));
        end else begin
          thr = ism3d_pkg::THR_W'($urandom);
        end
        send_beat(cmd, ism3d_pkg::COORD_W'($urandom), ism3d_pkg::COORD_W'($urandom),
                  ism3d_pkg::COORD_W'($urandom), thr);
      end
    end

    wait_drained(DRAIN_CYCLES);
    if (fail_count == 0) begin
      $display("ising_metropolis_3d_step_test: PASS");
    end else begin
      $display("ising_metropolis_3d_step_test: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
